### rtl/iprcl_pkg.sv
// shared types, constants and codes for the ipv4 range country lookup
// no dependencies; the controller, datapath and top level refer to this package by scoped names
package iprcl_pkg;

    // table capacity and the widths that follow from it
    localparam int TABLE_DEPTH = 65536;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] STS_MATCH     = 2'd0;
    localparam logic [1:0] STS_MALFORMED = 2'd1;
    localparam logic [1:0] STS_NO_MATCH  = 2'd2;

    // character codes and parser limits
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [7:0] CHAR_DOT  = 8'd46;
    localparam logic [9:0] QUAD_MAX  = 10'd255;
    localparam logic [2:0] LAST_DOT  = 3'd3;
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [7:0]  range_country;
        logic [7:0]  text_char;
        logic        last_char;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  country_index;
        logic [31:0] parsed_address;
    } t_out_item;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [7:0]  country;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;      // input item accepted this cycle
        logic scan_run;  // table scan in progress
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_query;  // offered item is the final query character
        logic needs_scan;  // that item gives a nonzero well formed address, table not empty
        logic scan_end;    // scan delivers its result this cycle
        logic out_busy;    // output register holds an item that stays
    } t_dp_stat;

endpackage

### rtl/iprcl_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module iprcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/iprcl_ctrl.sv
// controller: idle/scan state machine, input stall and datapath commands
// depends on iprcl_pkg
module iprcl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  iprcl_pkg::t_dp_stat i_stat,
    output logic                o_in_stall,
    output iprcl_pkg::t_dp_cmd  o_cmd
);

    iprcl_pkg::t_state r_state;
    iprcl_pkg::t_state n_state;
    logic              stall;
    logic              take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iprcl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        stall   = 1'b1;
        take    = 1'b0;
        unique case (r_state)
            iprcl_pkg::ST_IDLE: begin
                // a final query character needs a free output register
                stall = i_stat.last_query && i_stat.out_busy;
                take  = i_in_valid && !stall;
                if (take && i_stat.last_query && i_stat.needs_scan) begin
                    n_state = iprcl_pkg::ST_SCAN;
                end
            end
            iprcl_pkg::ST_SCAN: begin
                stall = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = iprcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iprcl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall     = stall;
    assign o_cmd.take     = take;
    assign o_cmd.scan_run = (r_state == iprcl_pkg::ST_SCAN);

endmodule

### rtl/iprcl_dp.sv
// datapath: query parser, entry count, range table, scan compare, output register
// depends on iprcl_pkg and iprcl_ram
module iprcl_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iprcl_pkg::t_in_item  i_in_item,
    input  iprcl_pkg::t_dp_cmd   i_cmd,
    input  logic                 i_out_stall,
    output iprcl_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    output iprcl_pkg::t_out_item o_out_item
);

    // parse state
    logic [23:0] r_acc;
    logic [9:0]  r_quad;
    logic [1:0]  r_digits;
    logic [2:0]  r_dots;
    logic        r_err;
    logic [23:0] n_acc;
    logic [9:0]  n_quad;
    logic [1:0]  n_digits;
    logic [2:0]  n_dots;
    logic        n_err;

    logic [iprcl_pkg::CNT_W-1:0] r_count;

    // scan state
    logic [31:0]                 r_addr;
    logic [iprcl_pkg::CNT_W-1:0] r_scan_idx;
    logic                        r_cmp_valid;
    logic                        r_cmp_last;

    logic                 r_out_valid;
    iprcl_pkg::t_out_item r_out_item;

    logic                  is_query;
    logic                  last_query;
    logic [7:0]            ch;
    logic [7:0]            digit;
    logic                  query_ok;
    logic [31:0]           query_addr;
    logic                  needs_scan;
    logic                  out_leaving;
    logic                  issue;
    logic                  hit;
    logic                  scan_end;
    logic                  we;
    iprcl_pkg::t_entry     wentry;
    logic [iprcl_pkg::ENTRY_W-1:0] rdata;
    iprcl_pkg::t_entry     rentry;

    assign ch         = i_in_item.text_char;
    assign digit      = ch - iprcl_pkg::CHAR_ZERO;
    assign is_query   = (i_in_item.command == iprcl_pkg::CMD_QUERY);
    assign last_query = is_query && i_in_item.last_char;

    // one character step of the parser
    always_comb begin
        n_acc    = r_acc;
        n_quad   = r_quad;
        n_digits = r_digits;
        n_dots   = r_dots;
        n_err    = r_err;
        if (!r_err) begin
            if (ch == iprcl_pkg::CHAR_DOT) begin
                if (r_dots >= iprcl_pkg::LAST_DOT || r_digits == 2'd0
                        || r_quad > iprcl_pkg::QUAD_MAX) begin
                    n_err = 1'b1;
                end else begin
                    n_acc    = {r_acc[15:0], r_quad[7:0]};
                    n_dots   = r_dots + 3'd1;
                    n_quad   = 10'd0;
                    n_digits = 2'd0;
                end
            end else if (ch < iprcl_pkg::CHAR_ZERO || ch > iprcl_pkg::CHAR_NINE
                    || r_digits >= iprcl_pkg::MAX_DIGITS) begin
                n_err = 1'b1;
            end else begin
                n_quad   = 10'((r_quad * 10'd10) + {2'b00, digit});
                n_digits = r_digits + 2'd1;
            end
        end
    end

    assign query_ok   = !n_err && n_dots == iprcl_pkg::LAST_DOT && n_digits != 2'd0
                        && n_quad <= iprcl_pkg::QUAD_MAX;
    assign query_addr = query_ok ? {n_acc, n_quad[7:0]} : 32'd0;
    assign needs_scan = query_ok && query_addr != 32'd0 && r_count != '0;

    // table ram: writes only while idle; its read data is used only while scanning
    assign we = i_cmd.take && i_in_item.command == iprcl_pkg::CMD_APPEND
                && r_count < iprcl_pkg::CNT_FULL;
    assign wentry.range_start = i_in_item.range_start;
    assign wentry.range_end   = i_in_item.range_end;
    assign wentry.country     = i_in_item.range_country;

    iprcl_ram #(
        .WIDTH (iprcl_pkg::ENTRY_W),
        .DEPTH (iprcl_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[iprcl_pkg::IDX_W-1:0]),
        .i_wdata (wentry),
        .i_raddr (r_scan_idx[iprcl_pkg::IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign rentry   = iprcl_pkg::t_entry'(rdata);
    assign issue    = i_cmd.scan_run && r_scan_idx < r_count;
    assign hit      = rentry.range_start <= r_addr && r_addr <= rentry.range_end;
    assign scan_end = i_cmd.scan_run && r_cmp_valid && (hit || r_cmp_last);

    assign out_leaving = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_quad      <= '0;
            r_digits    <= '0;
            r_dots      <= '0;
            r_err       <= 1'b0;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                if (i_in_item.command == iprcl_pkg::CMD_CLEAR) begin
                    r_count <= '0;
                end else if (we) begin
                    r_count <= r_count + 1'b1;
                end
                if (is_query) begin
                    if (i_in_item.last_char) begin
                        r_acc    <= '0;
                        r_quad   <= '0;
                        r_digits <= '0;
                        r_dots   <= '0;
                        r_err    <= 1'b0;
                    end else begin
                        r_acc    <= n_acc;
                        r_quad   <= n_quad;
                        r_digits <= n_digits;
                        r_dots   <= n_dots;
                        r_err    <= n_err;
                    end
                end
            end
            r_cmp_valid <= issue && !scan_end;
            // a scanning query raises valid only when its scan ends
            if ((i_cmd.take && last_query && !needs_scan) || scan_end) begin
                r_out_valid <= 1'b1;
            end else if (out_leaving) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan index and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && last_query && needs_scan) begin
            r_addr     <= query_addr;
            r_scan_idx <= '0;
        end else if (issue) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        r_cmp_last <= (r_scan_idx + 1'b1) == r_count;
        if (i_cmd.take && last_query) begin
            r_out_item.status         <= (query_ok && query_addr != 32'd0)
                                         ? iprcl_pkg::STS_NO_MATCH
                                         : iprcl_pkg::STS_MALFORMED;
            r_out_item.country_index  <= 8'd0;
            r_out_item.parsed_address <= query_addr;
        end else if (scan_end) begin
            r_out_item.status         <= hit ? iprcl_pkg::STS_MATCH : iprcl_pkg::STS_NO_MATCH;
            r_out_item.country_index  <= hit ? rentry.country : 8'd0;
            r_out_item.parsed_address <= r_addr;
        end
    end

    assign o_stat.last_query = last_query;
    assign o_stat.needs_scan = needs_scan;
    assign o_stat.scan_end   = scan_end;
    assign o_stat.out_busy   = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

### rtl/ipv4_range_country_lookup.sv
// top level of the ipv4 range to country lookup
// depends on iprcl_pkg, iprcl_ctrl, iprcl_dp (which holds iprcl_ram)
//
// Each input item is a clear, an append of one range (start, end, country) or
// one character of a dotted-decimal query. Clears, appends and non-final query
// characters are taken one per cycle while no scan runs. The final character
// of a well formed, nonzero address starts an in-order scan of the table held
// in a single ram: one entry is read per cycle and compared in the cycle after,
// and the input stalls until a match or the last entry is compared. A malformed
// or zero address, or a query against an empty table, is answered without a
// scan, its result registered as it is taken. The result sits in an output
// register; items that give no result keep flowing while it waits, and only
// the next final query character waits for it to be taken. Appends past
// capacity are dropped, and a clear only resets the entry count, so no
// clearing pass is needed.
module ipv4_range_country_lookup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  iprcl_pkg::t_in_item  i_in_item,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output iprcl_pkg::t_out_item o_out_item
);

    iprcl_pkg::t_dp_cmd  dp_cmd;
    iprcl_pkg::t_dp_stat dp_stat;

    // sequencing: idle vs table scan
    iprcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // parser, table and result register
    iprcl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

### sim/tb_ipv4_range_country_lookup.sv
// testbench for the ipv4 range to country lookup: directed and random items,
// each result checked against a predictor kept inside this module
// depends on iprcl_pkg and ipv4_range_country_lookup
`timescale 1ns / 1ps

module tb_ipv4_range_country_lookup;

    import iprcl_pkg::*;

    // command 3 has no name in the package, the block ignores it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int IDLE_PCT      = 21;    // idle share in percent
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 20;    // quiet cycles after the last result
    localparam int RANDOM_ITEMS  = 650;
    localparam int FILL_COUNT    = 48;    // entries in the long scan table
    localparam logic [31:0] FILL_BASE = 32'h0B00_0000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    ipv4_range_country_lookup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predicted state of the block
    // ------------------------------------------------------------------

    // range table, only entries below range_count are ever looked at
    logic [31:0] range_lo  [TABLE_DEPTH];
    logic [31:0] range_hi  [TABLE_DEPTH];
    logic [7:0]  range_cty [TABLE_DEPTH];
    int unsigned range_count = 0;

    // dotted-decimal parser state
    logic [31:0] addr_acc    = '0;
    logic [9:0]  quad_val    = '0;
    int          quad_digits = 0;
    int          dot_count   = 0;
    logic        parse_bad   = 1'b0;

    // answers still owed by the block, oldest first
    t_out_item expected_answers[$];

    int  fail_count  = 0;
    int  items_sent  = 0;
    bit  in_idle_on  = 1'b1;
    bit  out_idle_on = 1'b1;
    bit  hold_request = 1'b0;

    // characters of the next query
    logic [7:0] text_buf[$];

    task automatic reset_parser();
        addr_acc    = '0;
        quad_val    = '0;
        quad_digits = 0;
        dot_count   = 0;
        parse_bad   = 1'b0;
    endtask

    // one query character; once an error is seen the rest is ignored
    task automatic parse_char(input logic [7:0] ch);
        if (!parse_bad) begin
            if (ch == CHAR_DOT) begin
                if (dot_count >= LAST_DOT || quad_digits == 0 || quad_val > QUAD_MAX) begin
                    parse_bad = 1'b1;
                end else begin
                    addr_acc    = {addr_acc[23:0], quad_val[7:0]};
                    dot_count   = dot_count + 1;
                    quad_val    = '0;
                    quad_digits = 0;
                end
            end else if (ch < CHAR_ZERO || ch > CHAR_NINE || quad_digits >= MAX_DIGITS) begin
                parse_bad = 1'b1;
            end else begin
                quad_val    = 10'(quad_val * 10 + (ch - CHAR_ZERO));
                quad_digits = quad_digits + 1;
            end
        end
    endtask

    // update the predicted state for one accepted item, queue any answer
    task automatic predict_lookup(input t_in_item it);
        t_out_item   ans;
        logic [31:0] addr;
        int unsigned i;
        case (it.command)
            CMD_CLEAR: begin
                range_count = 0;
            end
            CMD_APPEND: begin
                // appends past capacity are dropped
                if (range_count < TABLE_DEPTH) begin
                    range_lo[range_count]  = it.range_start;
                    range_hi[range_count]  = it.range_end;
                    range_cty[range_count] = it.range_country;
                    range_count = range_count + 1;
                end
            end
            CMD_QUERY: begin
                parse_char(it.text_char);
                if (it.last_char) begin
                    ans.status         = STS_MALFORMED;
                    ans.country_index  = '0;
                    ans.parsed_address = '0;
                    if (!parse_bad && dot_count == LAST_DOT && quad_digits != 0
                            && quad_val <= QUAD_MAX) begin
                        addr = {addr_acc[23:0], quad_val[7:0]};
                        ans.parsed_address = addr;
                        // all-zero address stays malformed
                        if (addr != '0) begin
                            ans.status = STS_NO_MATCH;
                            // first inclusive range wins
                            for (i = 0; i < range_count; i++) begin
                                if (range_lo[i] <= addr && addr <= range_hi[i]) begin
                                    ans.status        = STS_MATCH;
                                    ans.country_index = range_cty[i];
                                    break;
                                end
                            end
                        end
                    end
                    reset_parser();
                    expected_answers.push_back(ans);
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // result side: check each accepted result, drive the stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_side
        t_out_item want;
        int        hold_left;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d country %0d addr %h",
                         $time, o_out_item.status, o_out_item.country_index,
                         o_out_item.parsed_address);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out_item.status);
                    fail_count++;
                end
                if (o_out_item.country_index !== want.country_index) begin
                    $display("%0t: country_index expected %0d actual %0d",
                             $time, want.country_index, o_out_item.country_index);
                    fail_count++;
                end
                if (o_out_item.parsed_address !== want.parsed_address) begin
                    $display("%0t: parsed_address expected %h actual %h",
                             $time, want.parsed_address, o_out_item.parsed_address);
                    fail_count++;
                end
            end
        end
        // a hold request turns into a long counted hold-off
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= out_idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int g;
        g = 0;
        if (in_idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) g++;
        end
        return g;
    endfunction

    // every field random, callers overwrite what matters
    function automatic t_in_item junk_item();
        t_in_item r;
        r.command       = 2'($urandom_range(0, 3));
        r.range_start   = $urandom;
        r.range_end     = $urandom;
        r.range_country = 8'($urandom);
        r.text_char     = 8'($urandom);
        r.last_char     = 1'($urandom);
        return r;
    endfunction

    // offer one item and wait until it is taken; valid stays high into
    // the next item when no gap is drawn
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_lookup(it);
        if (it.command != CMD_UNUSED) items_sent++;
    endtask

    task automatic send_clear();
        t_in_item it;
        it = junk_item();
        it.command = CMD_CLEAR;
        send_item(it);
    endtask

    task automatic send_append(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [7:0] cty);
        t_in_item it;
        it = junk_item();
        it.command       = CMD_APPEND;
        it.range_start   = lo;
        it.range_end     = hi;
        it.range_country = cty;
        send_item(it);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic fin);
        t_in_item it;
        it = junk_item();
        it.command   = CMD_QUERY;
        it.text_char = ch;
        it.last_char = fin;
        send_item(it);
    endtask

    // send text_buf, marking the last character only when fin is set
    task automatic send_buf(input logic fin);
        int k;
        for (k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], fin && (k == text_buf.size() - 1));
        end
    endtask

    task automatic send_text(input string s, input logic fin);
        int k;
        text_buf.delete();
        for (k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
        send_buf(fin);
    endtask

    // dotted-decimal text of an address, now and then with leading zeros
    task automatic fill_addr_text(input logic [31:0] a);
        int q;
        int v;
        int n;
        int z;
        text_buf.delete();
        for (q = 3; q >= 0; q--) begin
            v = a[8*q +: 8];
            n = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
            z = ($urandom_range(7) == 0) ? $urandom_range(0, 3 - n) : 0;
            repeat (z) text_buf.push_back(CHAR_ZERO);
            if (v >= 100) text_buf.push_back(CHAR_ZERO + 8'(v / 100));
            if (v >= 10) text_buf.push_back(CHAR_ZERO + 8'((v / 10) % 10));
            text_buf.push_back(CHAR_ZERO + 8'(v % 10));
            if (q > 0) text_buf.push_back(CHAR_DOT);
        end
    endtask

    // sender idles and waits until all answers are in
    task automatic wait_for_answers();
        i_in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // small random table, some ranges empty (end below start)
    task automatic build_random_table();
        int          n;
        logic [31:0] lo;
        logic [31:0] span;
        logic [32:0] sum;
        logic [31:0] hi;
        send_clear();
        n = $urandom_range(1, 12);
        repeat (n) begin
            lo   = $urandom;
            span = ($urandom_range(3) == 0) ? $urandom : ($urandom >> $urandom_range(8, 31));
            sum  = {1'b0, lo} + {1'b0, span};
            hi   = sum[32] ? '1 : sum[31:0];
            if ($urandom_range(9) == 0) hi = lo - 1;
            send_append(lo, hi, 8'($urandom_range(0, 243)));
        end
    endtask

    // address inside some table range about half the time
    function automatic logic [31:0] pick_addr();
        int          i;
        logic [63:0] width;
        if (range_count > 0 && $urandom_range(1) == 1) begin
            i = $urandom_range(0, range_count - 1);
            if (range_lo[i] <= range_hi[i]) begin
                width = 64'(range_hi[i]) - 64'(range_lo[i]) + 1;
                return range_lo[i] + 32'({$urandom, $urandom} % width);
            end
        end
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hits, extremes of the address space, first match wins
    task automatic test_basic_lookup();
        send_clear();
        send_append(32'h0102_0300, 32'h0102_03FF, 8'd7);
        send_append(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd243);
        send_append(32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
        send_text("1.2.3.4", 1'b1);
        send_text("255.255.255.255", 1'b1);
        send_text("009.9.9.9", 1'b1);
        send_text("0.0.0.1", 1'b1);
    endtask

    // every way the text can be malformed
    task automatic test_malformed_text();
        send_text("0.0.0.0", 1'b1);      // zero address
        send_text("1.2.3.", 1'b1);       // empty last quad
        send_text("1.2.3", 1'b1);        // too few quads
        send_text("1.2.3.4.", 1'b1);     // dot after the third dot
        send_text("1..3.4", 1'b1);       // dot closing an empty quad
        send_text("256.1.1.1", 1'b1);    // quad above 255 at a dot
        send_text("1.1.1.256", 1'b1);    // quad above 255 at the end
        send_text("1.1.1.0001", 1'b1);   // fourth digit
        send_text("1.a.2.3", 1'b1);      // foreign character, error sticks
        send_text("1.2", 1'b0);          // nul inside the text
        send_char(8'h00, 1'b0);
        send_text(".3.4", 1'b1);
        send_text("4.3.2.", 1'b0);       // nul as the last character
        send_char(8'h00, 1'b1);
    endtask

    // other commands during a query, with the last mark set on them
    task automatic test_interleaved_commands();
        t_in_item it;
        send_text("1.2.", 1'b0);
        it = junk_item();
        it.command   = CMD_APPEND;
        it.last_char = 1'b1;
        send_item(it);
        it = junk_item();
        it.command   = CMD_UNUSED;
        it.last_char = 1'b1;
        send_item(it);
        send_text("3.9", 1'b1);
        // clear leaves the query in progress alone
        send_text("10.", 1'b0);
        it = junk_item();
        it.command   = CMD_CLEAR;
        it.last_char = 1'b1;
        send_item(it);
        send_append(32'h0A00_0000, 32'h0AFF_FFFF, 8'd5);
        send_text("0.0.1", 1'b1);
        send_text("11.0.0.1", 1'b1);
        wait_for_answers();
    endtask

    // longer table, hits at both ends, a miss, then an empty table
    task automatic test_long_scan();
        int i;
        send_clear();
        for (i = 0; i < FILL_COUNT; i++) begin
            send_append(FILL_BASE + i, FILL_BASE + i, 8'(i % 244));
        end
        fill_addr_text(FILL_BASE + FILL_COUNT - 1);
        send_buf(1'b1);
        fill_addr_text(FILL_BASE);
        send_buf(1'b1);
        send_text("12.0.0.1", 1'b1);
        send_clear();
        send_text("11.0.0.0", 1'b1);     // empty table
        wait_for_answers();
    endtask

    // long receiver hold-off while queries keep coming, then a full drain
    task automatic test_backpressure();
        int k;
        build_random_table();
        wait_for_answers();
        hold_request = 1'b1;
        for (k = 0; k < 8; k++) begin
            fill_addr_text(pick_addr());
            send_buf(1'b1);
        end
        wait_for_answers();
    endtask

    // mostly well formed queries, some broken ones, noise and table rebuilds
    task automatic test_random_traffic();
        int base;
        int pick;
        int pos;
        build_random_table();
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            // a stretch in the middle runs with no idling on either side
            in_idle_on  = !(items_sent - base > 400 && items_sent - base < 600);
            out_idle_on = in_idle_on;
            pick = $urandom_range(99);
            if (pick < 65) begin
                fill_addr_text(pick_addr());
                send_buf(1'b1);
            end else if (pick < 82) begin
                fill_addr_text(pick_addr());
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(3))
                    0: text_buf[pos] = 8'($urandom);
                    1: text_buf.insert(pos, CHAR_ZERO + 8'($urandom_range(9)));
                    2: text_buf.delete(pos);
                    default: text_buf = text_buf[0:pos];
                endcase
                if (text_buf.size() == 0) text_buf.push_back(CHAR_DOT);
                send_buf(1'b1);
            end else if (pick < 87) begin
                build_random_table();
            end else if (pick < 94) begin
                send_item(junk_item());
            end else begin
                send_append($urandom, $urandom, 8'($urandom_range(0, 243)));
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_lookup();
        test_malformed_text();
        test_interleaved_commands();
        test_long_scan();
        test_backpressure();
        test_random_traffic();
        wait_for_answers();
        if (fail_count == 0 && expected_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard limit, far above the slowest correct run
    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/iprcl_pkg.sv
rtl/iprcl_ram.sv
rtl/iprcl_ctrl.sv
rtl/iprcl_dp.sv
rtl/ipv4_range_country_lookup.sv
sim/tb_ipv4_range_country_lookup.sv
